### rtl/rse_pkg.sv
// Shared types and constants of the rate spike row encoder.
`default_nettype none

package rse_pkg;

  // One memory row holds the pixels of one 32-bit row word.
  localparam int LANES = 32;
  localparam int LANE_AW = 5;
  localparam int PIX_W = 8;
  localparam int LANES_ON_W = 6;
  localparam int WIDX_W = 3;

  localparam int ACTIVE_W = 9;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 9'd256;

  localparam int DEF_TILE_PIXELS = 256;
  localparam int DEF_WORDS_PER_ROW = 8;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_e;

  typedef struct packed {
    op_e              operation;
    logic [7:0]       pixel_index;
    logic [PIX_W-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [WIDX_W-1:0] word_index;
    logic [LANES-1:0]  row_bits;
    logic              last_word;
  } out_item_t;

  typedef logic [LANES-1:0][PIX_W-1:0] lane_row_t;

  // Pixel index modulo the tile size by restoring subtraction, eight steps.
  function automatic logic [7:0] wrap_index(logic [7:0] idx, int tile);
    int r;
    r = int'(idx);
    for (int s = 7; s >= 0; s--) begin
      if (r >= (tile << s)) begin
        r = r - (tile << s);
      end
    end
    return 8'(r);
  endfunction

endpackage

`default_nettype wire

### rtl/rse_row_mem.sv
// Row-organized memory with per-lane write enables and a registered read port.
`default_nettype none

module rse_row_mem #(
  parameter int ROWS   = 8,
  parameter int ROW_AW = 3
) (
  input  wire logic                           clk_i,
  input  wire logic [rse_pkg::LANES-1:0]      wr_lanes_i,
  input  wire logic [ROW_AW-1:0]              wr_row_i,
  input  wire rse_pkg::lane_row_t             wr_data_i,
  input  wire logic                           rd_en_i,
  input  wire logic [ROW_AW-1:0]              rd_row_i,
  output rse_pkg::lane_row_t                  rd_data_o
);

  rse_pkg::lane_row_t mem_q [ROWS];
  rse_pkg::lane_row_t rd_data_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < rse_pkg::LANES; k++) begin
      if (wr_lanes_i[k]) begin
        mem_q[wr_row_i][k] <= wr_data_i[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/rse_lane_unit.sv
// Shared 32-lane accumulate and threshold unit, applied to one row word at a time.
`default_nettype none

module rse_lane_unit (
  input  wire rse_pkg::lane_row_t                  pix_row_i,
  input  wire rse_pkg::lane_row_t                  acc_row_i,
  input  wire logic [rse_pkg::LANES_ON_W-1:0]      lanes_on_i,
  output rse_pkg::lane_row_t                       acc_row_o,
  output logic [rse_pkg::LANES-1:0]                spikes_o
);

  logic [rse_pkg::LANES-1:0][rse_pkg::PIX_W:0] sum;

  // The sum stays below 512, so dropping its top bit subtracts the spike level.
  always_comb begin
    for (int k = 0; k < rse_pkg::LANES; k++) begin
      sum[k] = {1'b0, acc_row_i[k]} + {1'b0, pix_row_i[k]};
      if (rse_pkg::LANES_ON_W'(k) < lanes_on_i) begin
        spikes_o[k]  = sum[k][rse_pkg::PIX_W];
        acc_row_o[k] = sum[k][rse_pkg::PIX_W-1:0];
      end else begin
        spikes_o[k]  = 1'b0;
        acc_row_o[k] = acc_row_i[k];
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rate_spike_row_encoder_top.sv
// Top level of the rate spike row encoder: sequencer, memories and output register.
//
//   Port group      Dir  Transfer condition          Payload
//   in_*            in   in_valid_i & !in_stall_o    rse_pkg::in_item_t
//   out_*           out  out_valid_o & !out_stall_i  rse_pkg::out_item_t
//   cfg_*           in   cfg_we_i                    active pixel count, 9 bits
//
// After reset the accumulator memory is cleared one row per cycle, all ceil(TILE_PIXELS/32)
// rows (8 by default), and no item is taken until that is done.
// A step reads, for each word of the row that has a memory row, that row from the pixel
// and accumulator memories and passes it through the lane unit. An output stall holds
// the read stage and the sequencer.
// Loads are taken while the last word of a row still waits at the output.
`default_nettype none

module rate_spike_row_encoder_top #(
  parameter int TILE_PIXELS   = rse_pkg::DEF_TILE_PIXELS,
  parameter int WORDS_PER_ROW = rse_pkg::DEF_WORDS_PER_ROW
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire rse_pkg::in_item_t               in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output rse_pkg::out_item_t                   out_item_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rse_pkg::ACTIVE_W-1:0]    cfg_wdata_i
);

  localparam int ROWS     = (TILE_PIXELS + rse_pkg::LANES - 1) / rse_pkg::LANES;
  localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_BITS = WORDS_PER_ROW * rse_pkg::LANES;
  localparam int CAP      = (TILE_PIXELS < ROW_BITS) ? TILE_PIXELS : ROW_BITS;
  localparam int CNT_W    = $clog2(ROW_BITS + 1);
  localparam int WORD_W   = (WORDS_PER_ROW > 1) ? $clog2(WORDS_PER_ROW) : 1;
  localparam int ISS_W    = $clog2(WORDS_PER_ROW + 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STEP
  } state_e;

  state_e                         state_q;
  logic [ROW_AW-1:0]              clr_row_q;
  logic [ISS_W-1:0]               issue_q;
  logic                           rd_vld_q;
  logic [WORD_W-1:0]              rd_word_q;
  logic                           out_vld_q;
  rse_pkg::out_item_t             out_item_q;
  logic [rse_pkg::ACTIVE_W-1:0]   active_q;

  logic                           in_xfer;
  logic                           load_go;
  logic                           step_go;
  logic                           issue_go;
  logic                           capture;
  logic                           rd_row_ok;
  logic                           last_cap;
  logic [7:0]                     load_idx;
  logic [ROW_AW-1:0]              load_row;
  logic [rse_pkg::LANE_AW-1:0]    load_lane;

  logic [CNT_W-1:0]               n_usable;
  logic [CNT_W-1:0]               base;
  logic [CNT_W-1:0]               span;
  logic [rse_pkg::LANES_ON_W-1:0] lanes_on;

  logic [rse_pkg::LANES-1:0]      pix_wr_lanes;
  logic [ROW_AW-1:0]              pix_wr_row;
  rse_pkg::lane_row_t             pix_wr_data;
  logic [rse_pkg::LANES-1:0]      acc_wr_lanes;
  logic [ROW_AW-1:0]              acc_wr_row;
  rse_pkg::lane_row_t             acc_wr_data;
  logic                           rd_en;
  logic [ROW_AW-1:0]              rd_row;
  rse_pkg::lane_row_t             pix_rd;
  rse_pkg::lane_row_t             acc_rd;
  rse_pkg::lane_row_t             acc_new;
  logic [rse_pkg::LANES-1:0]      spikes;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign load_go     = in_xfer && (in_item_i.operation == rse_pkg::OP_LOAD);
  assign step_go     = in_xfer && (in_item_i.operation == rse_pkg::OP_STEP);

  assign capture     = rd_vld_q && (!out_vld_q || !out_stall_i);
  assign issue_go    = (state_q == ST_STEP) && (32'(issue_q) < WORDS_PER_ROW) &&
                       (!rd_vld_q || capture);
  assign rd_row_ok   = (32'(rd_word_q) < ROWS);
  assign last_cap    = capture && (32'(rd_word_q) == WORDS_PER_ROW - 1);

  assign rd_en       = issue_go && (32'(issue_q) < ROWS);
  assign rd_row      = ROW_AW'(issue_q);

  assign load_idx    = rse_pkg::wrap_index(in_item_i.pixel_index, TILE_PIXELS);
  assign load_row    = ROW_AW'(load_idx >> rse_pkg::LANE_AW);
  assign load_lane   = load_idx[rse_pkg::LANE_AW-1:0];

  // Number of lanes of the current word that belong to active pixels.
  always_comb begin
    n_usable = (32'(active_q) > CAP) ? CNT_W'(CAP) : CNT_W'(active_q);
    base     = CNT_W'({rd_word_q, {rse_pkg::LANE_AW{1'b0}}});
    span     = '0;
    if (n_usable > base) begin
      span = n_usable - base;
    end
    if (32'(span) >= rse_pkg::LANES) begin
      lanes_on = rse_pkg::LANES_ON_W'(rse_pkg::LANES);
    end else begin
      lanes_on = rse_pkg::LANES_ON_W'(span);
    end
  end

  // Write ports: the clearing pass, a load and a step write-back never overlap.
  always_comb begin
    pix_wr_lanes = '0;
    pix_wr_row   = load_row;
    pix_wr_data  = {rse_pkg::LANES{in_item_i.pixel_value}};
    acc_wr_lanes = '0;
    acc_wr_row   = load_row;
    acc_wr_data  = '0;
    if (state_q == ST_CLEAR) begin
      acc_wr_lanes = '1;
      acc_wr_row   = clr_row_q;
    end else if (load_go) begin
      pix_wr_lanes = rse_pkg::LANES'(1) << load_lane;
      acc_wr_lanes = rse_pkg::LANES'(1) << load_lane;
    end else if (capture && rd_row_ok) begin
      acc_wr_lanes = '1;
      acc_wr_row   = ROW_AW'(rd_word_q);
      acc_wr_data  = acc_new;
    end
  end

  rse_row_mem #(
    .ROWS   (ROWS),
    .ROW_AW (ROW_AW)
  ) u_pix_mem (
    .clk_i      (clk_i),
    .wr_lanes_i (pix_wr_lanes),
    .wr_row_i   (pix_wr_row),
    .wr_data_i  (pix_wr_data),
    .rd_en_i    (rd_en),
    .rd_row_i   (rd_row),
    .rd_data_o  (pix_rd)
  );

  rse_row_mem #(
    .ROWS   (ROWS),
    .ROW_AW (ROW_AW)
  ) u_acc_mem (
    .clk_i      (clk_i),
    .wr_lanes_i (acc_wr_lanes),
    .wr_row_i   (acc_wr_row),
    .wr_data_i  (acc_wr_data),
    .rd_en_i    (rd_en),
    .rd_row_i   (rd_row),
    .rd_data_o  (acc_rd)
  );

  rse_lane_unit u_lane_unit (
    .pix_row_i  (pix_rd),
    .acc_row_i  (acc_rd),
    .lanes_on_i (lanes_on),
    .acc_row_o  (acc_new),
    .spikes_o   (spikes)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= rse_pkg::ACTIVE_RESET;
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_row_q  <= '0;
      issue_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_word_q  <= '0;
      out_vld_q  <= 1'b0;
      out_item_q <= '0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_row_q <= clr_row_q + 1'b1;
          if (32'(clr_row_q) == ROWS - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (step_go) begin
            state_q <= ST_STEP;
            issue_q <= '0;
          end
        end
        ST_STEP: begin
          if (issue_go) begin
            issue_q <= issue_q + 1'b1;
          end
          if (last_cap) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      if (issue_go) begin
        rd_vld_q  <= 1'b1;
        rd_word_q <= WORD_W'(issue_q);
      end else if (capture) begin
        rd_vld_q  <= 1'b0;
      end

      if (capture) begin
        out_vld_q             <= 1'b1;
        out_item_q.word_index <= rse_pkg::WIDX_W'(rd_word_q);
        out_item_q.row_bits   <= spikes;
        out_item_q.last_word  <= (32'(rd_word_q) == WORDS_PER_ROW - 1);
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

  a_rd_only_in_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_STEP))
    else $error("read stage holds a word outside a step");

  a_issue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(issue_q) <= WORDS_PER_ROW)
    else $error("word issue counter ran past the row");

  a_rd_word_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (32'(rd_word_q) < 32'(issue_q)))
    else $error("word in read stage was not issued");

  a_last_ends_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_cap |=> (state_q == ST_IDLE) && out_vld_q && out_item_q.last_word)
    else $error("last word of a row did not end the step");

endmodule

`default_nettype wire
